[hw/rtl/srtf_pkg.sv]
// Shared types, constants and state encodings for the SRTF scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package srtf_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
   localparam int BURST_BITS = 16;
   localparam int TIME_BITS  = 32;

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [2:0] STAT_ADD_OK   = 3'd0;
   localparam logic [2:0] STAT_ADD_REJ  = 3'd1;
   localparam logic [2:0] STAT_IDLE     = 3'd2;
   localparam logic [2:0] STAT_RAN      = 3'd3;
   localparam logic [2:0] STAT_FINISHED = 3'd4;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  job_slot;
      logic [15:0] burst;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  ran_slot;
      logic [15:0] remaining_after;
      logic [31:0] completion_time;
      logic [31:0] turnaround;
      logic [31:0] waiting;
   } rsp_type;

   typedef struct packed {
      logic [BURST_BITS-1:0] remaining;
      logic [BURST_BITS-1:0] burst;
      logic [TIME_BITS-1:0]  arrival;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FETCH,
      S_UPDATE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic add_accept;
      logic tick_start;
      logic scan_issue;
      logic fetch;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/srtf_scheduler_top.sv]
// Top level of the SRTF scheduler: srtf_ctrl sequencer plus srtf_datapath.
// Add: result registered, valid in the cycle after the transfer; next item may start in that cycle.
// Tick: SCAN (one slot per cycle of the 16-entry slot memory, through its single read
// port), DRAIN, FETCH, UPDATE, FINISH, then the registered result; busy until FINISH.
// Synchronous active-high reset clears all slots to free and the time counter to zero.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module srtf_scheduler_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  srtf_pkg::req_type_type req_item,
   output logic                   rsp_valid,
   output srtf_pkg::rsp_type      rsp_item
);
   import srtf_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   srtf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_tick (req_item.req_type),
      .dp_status   (dp_status),
      .busy        (busy),
      .cmd         (cmd)
   );

   srtf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[hw/rtl/srtf_ctrl.sv]
// Sequencing state machine for the SRTF scheduler: accept, slot scan, update, respond.
// Depends on srtf_pkg.
`default_nettype none

module srtf_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire                    req_is_tick,
   input  srtf_pkg::dp_status_type dp_status,
   output logic                   busy,
   output srtf_pkg::cmd_type      cmd
);
   import srtf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_is_tick == REQ_TICK) begin
                  cmd.tick_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.add_accept = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (dp_status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/srtf_datapath.sv]
// Slot table, active flags, time counter, min-search registers and response register.
// Depends on srtf_pkg; driven by srtf_ctrl commands.
`default_nettype none

module srtf_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  srtf_pkg::cmd_type       cmd,
   input  srtf_pkg::req_type_type  req_item,
   output srtf_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   output srtf_pkg::rsp_type       rsp_item
);
   import srtf_pkg::*;

   entry_type mem [NUM_SLOTS];
   entry_type rd_q;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_BITS-1:0] wr_addr;
   entry_type            wr_data;
   logic                 wr_en;

   logic [NUM_SLOTS-1:0] active_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic                 cmp_valid_ff;
   logic [SLOT_BITS-1:0] cmp_slot_ff;
   logic                 found_ff;
   logic [SLOT_BITS-1:0] best_slot_ff;
   logic [BURST_BITS-1:0] best_rem_ff;
   logic [TIME_BITS-1:0]  best_arr_ff;
   logic [BURST_BITS-1:0] rem_ff;
   logic [BURST_BITS-1:0] burst_ff;
   logic [TIME_BITS-1:0]  tat_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                  add_ok;
   logic                  take;
   logic [BURST_BITS-1:0] rem_new;

   assign add_ok  = !active_ff[req_item.job_slot[SLOT_BITS-1:0]] && (req_item.burst != '0);
   assign take    = cmp_valid_ff && (!found_ff || (rd_q.remaining < best_rem_ff) ||
                    ((rd_q.remaining == best_rem_ff) && (rd_q.arrival < best_arr_ff)));
   assign rem_new = best_rem_ff - BURST_BITS'(1);

   assign rd_addr = cmd.scan_issue ? idx_ff : best_slot_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_slot_ff;
      wr_data = '{remaining: rem_new, burst: rd_q.burst, arrival: best_arr_ff};
      if (cmd.add_accept) begin
         wr_en   = add_ok;
         wr_addr = req_item.job_slot[SLOT_BITS-1:0];
         wr_data = '{remaining: req_item.burst, burst: req_item.burst, arrival: now_ff};
      end else if (cmd.update) begin
         wr_en = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   assign dp_status.scan_last = (idx_ff == SLOT_BITS'(NUM_SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         now_ff       <= '0;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_issue && active_ff[idx_ff];
         rsp_valid_ff <= cmd.add_accept || cmd.finish;
         if (cmd.add_accept && add_ok) begin
            active_ff[req_item.job_slot[SLOT_BITS-1:0]] <= 1'b1;
         end
         if (cmd.tick_start) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               idx_ff <= idx_ff + SLOT_BITS'(1);
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.fetch) begin
            now_ff <= now_ff + TIME_BITS'(1);
         end
         if (cmd.update && found_ff && (rem_new == '0)) begin
            active_ff[best_slot_ff] <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.add_accept) begin
         rsp_in.status   = add_ok ? STAT_ADD_OK : STAT_ADD_REJ;
         rsp_in.ran_slot = req_item.job_slot;
      end else if (!found_ff) begin
         rsp_in.status = STAT_IDLE;
      end else if (rem_ff != '0) begin
         rsp_in.status          = STAT_RAN;
         rsp_in.ran_slot        = 4'(best_slot_ff);
         rsp_in.remaining_after = 16'(rem_ff);
      end else begin
         rsp_in.status          = STAT_FINISHED;
         rsp_in.ran_slot        = 4'(best_slot_ff);
         rsp_in.completion_time = 32'(now_ff);
         rsp_in.turnaround      = 32'(tat_ff);
         rsp_in.waiting         = 32'(tat_ff - TIME_BITS'(burst_ff));
      end
   end

   always_ff @(posedge clock) begin
      cmp_slot_ff <= idx_ff;
      if (take) begin
         best_slot_ff <= cmp_slot_ff;
         best_rem_ff  <= rd_q.remaining;
         best_arr_ff  <= rd_q.arrival;
      end
      if (cmd.update) begin
         rem_ff   <= rem_new;
         burst_ff <= rd_q.burst;
         tat_ff   <= now_ff - best_arr_ff;
      end
      if (cmd.add_accept || cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/srtf_checker.sv]
// Port-level checks for srtf_scheduler_top, bound to the top level.
// Depends on srtf_pkg.
`default_nettype none

module srtf_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    start,
   input wire                    busy,
   input srtf_pkg::req_type_type req_item,
   input wire                    rsp_valid,
   input srtf_pkg::rsp_type      rsp_item
);
   import srtf_pkg::*;

   a_add_responds: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.req_type == REQ_ADD) |=> rsp_valid)
      else $error("add transfer without response");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.req_type == REQ_TICK) |=> (busy && !rsp_valid))
      else $error("tick transfer did not enter busy");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   a_ran_remaining: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STAT_RAN) |-> (rsp_item.remaining_after != '0))
      else $error("ran with zero remaining");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STAT_IDLE) |->
      (rsp_item.ran_slot == '0 && rsp_item.completion_time == '0))
      else $error("idle tick with nonzero fields");

endmodule

bind srtf_scheduler_top srtf_checker u_srtf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
